[rtl/fcspq_pkg.sv]
// shared types and constants for the four-class strict priority queue
`timescale 1ns / 1ps
package fcspq_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int PAY_W       = 16;
    localparam int AGE_W       = 7;
    localparam int ENTRY_W     = PAY_W + AGE_W + 1;
    localparam int STAT_W      = 2;

    localparam logic [AGE_W-1:0] AGE_THR_RESET = 7'd60;

    // operation codes on the input word
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_SERVED = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic enq_write;
        logic deq_read;
        logic load_full;
        logic load_empty;
        logic load_served;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sel_full;
        logic any_nonempty;
        logic out_valid;
    } t_stat;

endpackage

[rtl/fcspq_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module fcspq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fcspq_ctrl.sv]
// controller state machine: input handshake and datapath commands
`timescale 1ns / 1ps
module fcspq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    input  logic           i_out_stall,
    input  fcspq_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output fcspq_pkg::t_cmd  o_cmd
);
    import fcspq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    // hold input while a read is in flight or the result word cannot move
    assign o_in_stall = (r_state != S_IDLE) || (i_stat.out_valid && i_out_stall);
    assign in_fire    = i_in_valid && !o_in_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_op == OP_ENQ) begin
                        if (i_stat.sel_full) begin
                            o_cmd.load_full = 1'b1;
                        end else begin
                            o_cmd.enq_write = 1'b1;
                        end
                    end else if (i_stat.any_nonempty) begin
                        o_cmd.deq_read = 1'b1;
                        n_state        = S_READ;
                    end else begin
                        o_cmd.load_empty = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_served = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/fcspq_dp.sv]
// datapath: class pointers, occupancy, entry ram, threshold and result register
`timescale 1ns / 1ps
module fcspq_dp #(
    parameter int CLASS_DEPTH = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fcspq_pkg::t_cmd                   i_cmd,
    input  logic [fcspq_pkg::PAY_W-1:0]       i_payload,
    input  logic [fcspq_pkg::AGE_W-1:0]       i_age,
    input  logic                              i_risk,
    input  logic                              i_cfg_wr_en,
    input  logic [fcspq_pkg::AGE_W-1:0]       i_cfg_wr_data,
    input  logic                              i_out_stall,
    output fcspq_pkg::t_stat                  o_stat,
    output logic                              o_out_valid,
    output logic [fcspq_pkg::STAT_W-1:0]      o_status,
    output logic [fcspq_pkg::PAY_W-1:0]       o_payload_out,
    output logic [fcspq_pkg::AGE_W-1:0]       o_age_out,
    output logic                              o_risk_out
);
    import fcspq_pkg::*;

    localparam int PW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam int AW = CLS_W + PW;
    localparam int RAM_DEPTH = NUM_CLASSES << PW;

    logic [PW-1:0]    r_head  [NUM_CLASSES];
    logic [PW-1:0]    r_tail  [NUM_CLASSES];
    logic [CW-1:0]    r_count [NUM_CLASSES];
    logic [AGE_W-1:0] r_age_thr;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [PAY_W-1:0]   r_payload_out;
    logic [AGE_W-1:0]   r_age_out;
    logic               r_risk_out;

    logic [NUM_CLASSES-1:0] nonempty;
    logic [NUM_CLASSES-1:0] full;
    logic [CLS_W-1:0]       enq_cls;
    logic [CLS_W-1:0]       deq_cls;
    logic                   aged;
    logic [PW-1:0]          tail_sel;
    logic [PW-1:0]          head_sel;
    logic [PW-1:0]          tail_nxt;
    logic [PW-1:0]          head_nxt;
    logic [ENTRY_W-1:0]     rdata;

    // per-class occupancy flags
    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            nonempty[k] = (r_count[k] != '0);
            full[k]     = (r_count[k] == CW'(CLASS_DEPTH));
        end
    end

    // class of an incoming record: {no risk, not aged}
    assign aged    = (i_age >= r_age_thr);
    assign enq_cls = {~i_risk, ~aged};

    // highest priority non-empty class
    always_comb begin
        deq_cls = CLS_W'(NUM_CLASSES - 1);
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (nonempty[k]) begin
                deq_cls = CLS_W'(k);
            end
        end
    end

    assign tail_sel = r_tail[enq_cls];
    assign head_sel = r_head[deq_cls];
    assign tail_nxt = (tail_sel == PW'(CLASS_DEPTH - 1)) ? '0 : tail_sel + PW'(1);
    assign head_nxt = (head_sel == PW'(CLASS_DEPTH - 1)) ? '0 : head_sel + PW'(1);

    assign o_stat.sel_full     = full[enq_cls];
    assign o_stat.any_nonempty = |nonempty;
    assign o_stat.out_valid    = r_out_valid;

    // pointer and occupancy update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            if (i_cmd.enq_write) begin
                r_tail[enq_cls]  <= tail_nxt;
                r_count[enq_cls] <= r_count[enq_cls] + CW'(1);
            end
            if (i_cmd.deq_read) begin
                r_head[deq_cls]  <= head_nxt;
                r_count[deq_cls] <= r_count[deq_cls] - CW'(1);
            end
        end
    end

    // age threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_thr <= AGE_THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_age_thr <= i_cfg_wr_data;
        end
    end

    // entry store, addressed by {class, position}
    fcspq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq_write),
        .i_waddr (AW'({enq_cls, tail_sel})),
        .i_wdata ({i_payload, i_age, i_risk}),
        .i_re    (i_cmd.deq_read),
        .i_raddr (AW'({deq_cls, head_sel})),
        .o_rdata (rdata)
    );

    // result word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_full || i_cmd.load_empty || i_cmd.load_served) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_served) begin
            r_status      <= ST_SERVED;
            r_payload_out <= rdata[ENTRY_W-1 -: PAY_W];
            r_age_out     <= rdata[AGE_W:1];
            r_risk_out    <= rdata[0];
        end else if (i_cmd.load_full || i_cmd.load_empty) begin
            r_status      <= i_cmd.load_full ? ST_FULL : ST_EMPTY;
            r_payload_out <= '0;
            r_age_out     <= '0;
            r_risk_out    <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_payload_out = r_payload_out;
    assign o_age_out     = r_age_out;
    assign o_risk_out    = r_risk_out;

endmodule

[rtl/four_class_strict_priority_queue.sv]
// four-class strict priority queue, fifo order inside each class
// result: a full or empty report is in the result word in the cycle after the input word is
// taken; a served record goes through the registered ram read, then the result register
// throughput: an enqueue every cycle unless a read is in flight or the output is stalled
// reset: pointers and occupancy clear, threshold returns to 60; the entry ram is not cleared
`timescale 1ns / 1ps
module four_class_strict_priority_queue #(
    parameter int CLASS_DEPTH = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fcspq_pkg::AGE_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [fcspq_pkg::PAY_W-1:0]   i_payload,
    input  logic [fcspq_pkg::AGE_W-1:0]   i_age,
    input  logic                          i_risk,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fcspq_pkg::STAT_W-1:0]  o_status,
    output logic [fcspq_pkg::PAY_W-1:0]   o_payload_out,
    output logic [fcspq_pkg::AGE_W-1:0]   o_age_out,
    output logic                          o_risk_out
);
    import fcspq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // controller
    fcspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    // datapath
    fcspq_dp #(
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_payload     (i_payload),
        .i_age         (i_age),
        .i_risk        (i_risk),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_payload_out (o_payload_out),
        .o_age_out     (o_age_out),
        .o_risk_out    (o_risk_out)
    );

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    // a ram read is always followed by loading the served record
    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.deq_read |=> cmd.load_served)
        else $error("served record not loaded after ram read");

    // no new input word is taken while a read is in flight
    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.deq_read |=> o_in_stall)
        else $error("input taken while ram read in flight");

    // a loaded result word is presented the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_full || cmd.load_empty || cmd.load_served) |=> o_out_valid)
        else $error("result word not presented after load");

endmodule
